/* src/lru_timestamp_replacement_macros.svh */
// ----------------------------------------------------------------------------
// lru timestamp replacement assertion macros
// shared assertion forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef LRU_TIMESTAMP_REPLACEMENT_MACROS_SVH
`define LRU_TIMESTAMP_REPLACEMENT_MACROS_SVH

// same-cycle implication
`define LRU_TS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru_ts: same-cycle check failed");

// next-cycle implication
`define LRU_TS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru_ts: next-cycle check failed");

`endif

/* src/lru_ts_pkg.sv */
// ----------------------------------------------------------------------------
// lru_ts_pkg
// shared constants, action codes, state and control types
// ----------------------------------------------------------------------------
package lru_ts_pkg;

  localparam int SETS_DEF       = 64;
  localparam int WAYS_DEF       = 16;
  localparam int STAMP_BITS_DEF = 64;

  localparam int ACTION_W = 2;
  localparam int SET_IDX_W = 6;
  localparam int WAY_IDX_W = 4;

  localparam logic [ACTION_W-1:0] ACT_VICTIM = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FILL   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic scan_step;
    logic best_clr;
    logic stamp_en;
    logic clr_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_victim;
    logic set_ok;
    logic stamp_ok;
    logic scan_last;
    logic clr_last;
  } status_t;

endpackage

/* src/lru_ts_ctrl.sv */
// ----------------------------------------------------------------------------
// lru_ts_ctrl
// sequencer for clearing pass, victim scan and stamp writes
// ----------------------------------------------------------------------------
module lru_ts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lru_ts_pkg::status_t status,
  output lru_ts_pkg::cmd_t    cmd,
  output logic               busy,
  output logic               done
);

  lru_ts_pkg::state_t state;
  lru_ts_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lru_ts_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lru_ts_pkg::ST_CLEAR: begin
        if (status.clr_last) state_next = lru_ts_pkg::ST_IDLE;
      end
      lru_ts_pkg::ST_IDLE: begin
        if (start && status.req_victim) begin
          state_next = status.set_ok ? lru_ts_pkg::ST_SCAN : lru_ts_pkg::ST_DONE;
        end
      end
      lru_ts_pkg::ST_SCAN: begin
        if (status.scan_last) state_next = lru_ts_pkg::ST_DRAIN;
      end
      lru_ts_pkg::ST_DRAIN: state_next = lru_ts_pkg::ST_DONE;
      lru_ts_pkg::ST_DONE:  state_next = lru_ts_pkg::ST_IDLE;
      default:              state_next = lru_ts_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      lru_ts_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      lru_ts_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch    = status.req_victim;
          cmd.best_clr = status.req_victim && !status.set_ok;
          cmd.stamp_en = status.stamp_ok;
        end
      end
      lru_ts_pkg::ST_SCAN:  cmd.scan_step = 1'b1;
      lru_ts_pkg::ST_DRAIN: ;
      lru_ts_pkg::ST_DONE:  done = 1'b1;
      default: ;
    endcase
  end

endmodule

/* src/lru_ts_dp.sv */
// ----------------------------------------------------------------------------
// lru_ts_dp
// stamp memory, stamp counter, request decode and minimum search
// ----------------------------------------------------------------------------
module lru_ts_dp #(
  parameter int SETS       = lru_ts_pkg::SETS_DEF,
  parameter int WAYS       = lru_ts_pkg::WAYS_DEF,
  parameter int STAMP_BITS = lru_ts_pkg::STAMP_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lru_ts_pkg::cmd_t                    cmd,
  output lru_ts_pkg::status_t                 status,
  input  logic [lru_ts_pkg::ACTION_W-1:0]     action,
  input  logic [lru_ts_pkg::SET_IDX_W-1:0]    set_index,
  input  logic [lru_ts_pkg::WAY_IDX_W-1:0]    way,
  input  logic                                is_hit,
  input  logic                                is_write,
  output logic [lru_ts_pkg::WAY_IDX_W-1:0]    evict_way
);

  localparam int DEPTH  = SETS * WAYS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WAY_W  = $clog2(WAYS);
  localparam int OUT_W  = lru_ts_pkg::WAY_IDX_W;

  logic [STAMP_BITS-1:0] mem [DEPTH];
  logic [STAMP_BITS-1:0] rdata;
  logic [STAMP_BITS-1:0] stamp_counter;
  logic [STAMP_BITS-1:0] best_stamp;
  logic [WAY_W-1:0]      best_way;
  logic [WAY_W-1:0]      scan_idx;
  logic [WAY_W-1:0]      rd_way;
  logic                  rd_pending;
  logic                  rd_first;
  logic [ADDR_W-1:0]     base_q;
  logic [ADDR_W-1:0]     clr_addr;
  logic [ADDR_W-1:0]     in_base;
  logic [ADDR_W-1:0]     stamp_addr;
  logic                  set_ok;
  logic                  way_ok;
  logic                  stamp_req;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [STAMP_BITS-1:0] wdata;

  // request decode
  assign set_ok     = 32'(set_index) < SETS;
  assign way_ok     = 32'(way) < WAYS;
  assign in_base    = ADDR_W'(ADDR_W'(set_index) * ADDR_W'(WAYS));
  assign stamp_addr = in_base + ADDR_W'(way);

  always_comb begin
    case (action)
      lru_ts_pkg::ACT_FILL:   stamp_req = 1'b1;
      lru_ts_pkg::ACT_UPDATE: stamp_req = is_hit && !is_write;
      default:                stamp_req = 1'b0;
    endcase
  end

  assign status.req_victim = (action == lru_ts_pkg::ACT_VICTIM);
  assign status.set_ok     = set_ok;
  assign status.stamp_ok   = stamp_req && set_ok && way_ok;
  assign status.scan_last  = (scan_idx == WAY_W'(WAYS - 1));
  assign status.clr_last   = (clr_addr == ADDR_W'(DEPTH - 1));

  // memory write: clearing pass or stamp
  assign we    = cmd.clr_step || cmd.stamp_en;
  assign waddr = cmd.clr_step ? clr_addr : stamp_addr;
  assign wdata = cmd.clr_step ? '0 : stamp_counter;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) rdata <= mem[base_q + ADDR_W'(scan_idx)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_counter <= '0;
      clr_addr      <= '0;
      rd_pending    <= 1'b0;
      scan_idx      <= '0;
    end else begin
      if (cmd.stamp_en) stamp_counter <= stamp_counter + 1'b1;
      if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.latch) begin
        scan_idx <= '0;
      end else if (cmd.scan_step) begin
        scan_idx <= scan_idx + 1'b1;
      end
      rd_pending <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) base_q <= in_base;
    rd_first <= (scan_idx == '0);
    rd_way   <= scan_idx;
    if (cmd.best_clr) begin
      best_way <= '0;
    end else if (rd_pending && (rd_first || rdata < best_stamp)) begin
      best_stamp <= rdata;
      best_way   <= rd_way;
    end
  end

  assign evict_way = OUT_W'(best_way);

endmodule

/* src/lru_timestamp_replacement.sv */
// ----------------------------------------------------------------------------
// lru_timestamp_replacement
// true-lru replacement state kept as one use stamp per set and way
// ----------------------------------------------------------------------------
// usage:
//   an item is taken at a rising edge with start high and busy low; it
//   carries action, set_index, way, is_hit and is_write on their own ports
//   fill and refreshing access update write the global stamp counter into
//   the addressed way and bump the counter; busy stays low, so updates
//   can arrive back to back
//   a victim request scans the set one way per cycle through the single
//   read port of the stamp memory; done pulses for one cycle with
//   evict_way after the scan and a drain of the last read; busy stays high
//   until then, and the next item can be taken the cycle after done
//   a victim request for a set beyond SETS skips the scan and answers way 0
//   the result stays until the next victim request; the receiver takes it
//   in the done cycle
//   reset clears the counter and starts a clearing pass that zeroes the
//   stamp memory one entry a cycle; busy is high until the pass ends
// ----------------------------------------------------------------------------
`include "lru_timestamp_replacement_macros.svh"

module lru_timestamp_replacement #(
  parameter int SETS       = lru_ts_pkg::SETS_DEF,
  parameter int WAYS       = lru_ts_pkg::WAYS_DEF,
  parameter int STAMP_BITS = lru_ts_pkg::STAMP_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [lru_ts_pkg::ACTION_W-1:0]  action,
  input  logic [lru_ts_pkg::SET_IDX_W-1:0] set_index,
  input  logic [lru_ts_pkg::WAY_IDX_W-1:0] way,
  input  logic                             is_hit,
  input  logic                             is_write,
  output logic                             done,
  output logic [lru_ts_pkg::WAY_IDX_W-1:0] evict_way
);

  // command and status between sequencer and datapath
  lru_ts_pkg::cmd_t    cmd;
  lru_ts_pkg::status_t status;

  // sequencer: clearing pass, scan, drain of the last read, result cycle
  lru_ts_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // datapath: stamp memory, counter, running minimum
  lru_ts_dp #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .action    (action),
    .set_index (set_index),
    .way       (way),
    .is_hit    (is_hit),
    .is_write  (is_write),
    .evict_way (evict_way)
  );

  // result cycle belongs to an item in flight
  `LRU_TS_ASSERT_SAME(a_done_busy, done, busy)
  // result strobe lasts one cycle
  `LRU_TS_ASSERT_NEXT(a_done_pulse, done, !done)
  // a fill never blocks the next item
  `LRU_TS_ASSERT_NEXT(a_fill_free, start && !busy && action == lru_ts_pkg::ACT_FILL, !busy)
  // a victim request always keeps busy high in the cycle after its accept
  `LRU_TS_ASSERT_NEXT(a_victim_busy, start && !busy && action == lru_ts_pkg::ACT_VICTIM, busy)

endmodule
